// File: rtl/ldr_lux_pkg.sv
// Shared constants, codes and coefficient tables for the LDR lux converter.
package ldr_lux_pkg;

  localparam int ADC_BITS_DEF = 12;
  localparam int FRAC_BITS    = 24;
  localparam int NORM_STEPS   = 5;

  // Pipeline register positions, counted from the entry register.
  localparam int ST_NUM   = 1;
  localparam int ST_LOG0  = ST_NUM + NORM_STEPS + 1;
  localparam int ST_DIFF  = ST_LOG0 + FRAC_BITS;
  localparam int ST_PROD  = ST_DIFF + 1;
  localparam int ST_EXP0  = ST_PROD + 1;
  localparam int ST_PA    = ST_EXP0 + FRAC_BITS;
  localparam int ST_PB    = ST_PA + 1;
  localparam int ST_PC    = ST_PB + 1;
  // Cycles from the accepting edge to the edge that takes the result.
  localparam int LATENCY  = ST_PC + 2;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NO_RES = 2'd1,
    ST_SAT    = 2'd2,
    ST_RANGE  = 2'd3
  } status_t;

  localparam logic [2:0] REG_FULL_SCALE = 3'd0;
  localparam logic [2:0] REG_SERIES_RES = 3'd1;
  localparam logic [2:0] REG_SCALAR     = 3'd2;
  localparam logic [2:0] REG_EXPONENT   = 3'd3;
  localparam logic [2:0] REG_PUBLISH    = 3'd4;

  localparam logic [11:0] FULL_SCALE_RST = 12'd1023;
  localparam logic [19:0] SERIES_RES_RST = 20'd10000;
  localparam logic [47:0] SCALAR_RST     = 48'd820440662016;
  localparam logic [15:0] EXPONENT_RST   = 16'hE985;
  localparam logic        PUBLISH_RST    = 1'b1;

  localparam logic signed [40:0] VALUE_MAX = {1'b0, {40{1'b1}}};
  localparam logic signed [40:0] VALUE_NEG_ONE = -41'sd256;

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    rem  = v;
    res  = '0;
    bitv = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Slice j holds 2^(2^(j-FRAC_BITS)) in Q1.31, by repeated square roots.
  function automatic logic [FRAC_BITS*32-1:0] exp2_table();
    logic [FRAC_BITS*32-1:0] tab;
    logic [63:0] c;
    tab = '0;
    c   = 64'h1_0000_0000;
    for (int j = FRAC_BITS - 1; j >= 0; j--) begin
      c = isqrt64(c << 31);
      tab[j*32 +: 32] = c[31:0];
    end
    return tab;
  endfunction

  localparam logic [FRAC_BITS*32-1:0] EXP_TAB = exp2_table();

endpackage

// File: rtl/ldr_adc_to_lux_top.sv
// LDR lux converter: one sample per cycle, result strobed by done.
// One sample per cycle is sustained. Depth is set by the 24-step log2 squaring
// chain, the 24-step exp2 multiply chain and the split 48x32 scaling multiply.
// The receiver cannot stall, so busy stays low. Reset empties the pipeline and
// loads the configuration registers with their defaults.
module ldr_adc_to_lux_top #(
  parameter int ADC_BITS = ldr_lux_pkg::ADC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [ADC_BITS-1:0] sample,
  output logic                busy,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [47:0]         cfg_data,
  output logic                done,
  output logic signed [40:0]  value,
  output logic [1:0]          status
);

  localparam int RAW_W = (ADC_BITS > 12) ? ADC_BITS : 12;
  localparam int FB    = ldr_lux_pkg::FRAC_BITS;
  localparam int NS    = ldr_lux_pkg::NORM_STEPS;
  localparam int LAST  = ldr_lux_pkg::ST_PC;

  typedef struct packed {
    logic        valid;
    logic        spec;
    logic [40:0] sval;
    logic [1:0]  sst;
  } side_t;

  // Configuration registers.
  logic [11:0]        full_scale;
  logic [19:0]        series_resistance;
  logic [47:0]        lux_scalar;
  logic signed [15:0] lux_exponent;
  logic               publish_lux;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale        <= ldr_lux_pkg::FULL_SCALE_RST;
      series_resistance <= ldr_lux_pkg::SERIES_RES_RST;
      lux_scalar        <= ldr_lux_pkg::SCALAR_RST;
      lux_exponent      <= ldr_lux_pkg::EXPONENT_RST;
      publish_lux       <= ldr_lux_pkg::PUBLISH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ldr_lux_pkg::REG_FULL_SCALE: full_scale        <= cfg_data[11:0];
        ldr_lux_pkg::REG_SERIES_RES: series_resistance <= cfg_data[19:0];
        ldr_lux_pkg::REG_SCALAR:     lux_scalar        <= cfg_data[47:0];
        ldr_lux_pkg::REG_EXPONENT:   lux_exponent      <= cfg_data[15:0];
        ldr_lux_pkg::REG_PUBLISH:    publish_lux       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Entry stage: special cases are settled here and ride along the pipeline.
  logic [RAW_W-1:0] raw;
  logic [RAW_W-1:0] fs_w;
  side_t            side_in;

  assign raw  = RAW_W'(sample);
  assign fs_w = RAW_W'(full_scale);

  always_comb begin
    side_in.valid = start && !busy;
    side_in.spec  = 1'b1;
    side_in.sval  = '0;
    side_in.sst   = ldr_lux_pkg::ST_OK;
    priority if (!publish_lux) begin
      side_in.sval = 41'(raw) << 8;
    end else if (series_resistance == '0) begin
      side_in.sval = ldr_lux_pkg::VALUE_NEG_ONE;
      side_in.sst  = ldr_lux_pkg::ST_NO_RES;
    end else if (raw > fs_w) begin
      side_in.sst  = ldr_lux_pkg::ST_RANGE;
    end else if (raw == '0) begin
      side_in.sst  = ldr_lux_pkg::ST_SAT;
      if (lux_exponent < 0) side_in.sval = '0;
      else if (lux_exponent == 0) side_in.sval = {1'b0, lux_scalar[47:8]};
      else side_in.sval = ldr_lux_pkg::VALUE_MAX;
    end else if (raw == fs_w) begin
      if (lux_exponent > 0) begin
        side_in.sval = '0;
      end else if (lux_exponent == 0) begin
        side_in.sval = {1'b0, lux_scalar[47:8]};
      end else begin
        side_in.sval = ldr_lux_pkg::VALUE_MAX;
        side_in.sst  = ldr_lux_pkg::ST_SAT;
      end
    end else begin
      side_in.spec = 1'b0;
    end
  end

  side_t side [0:LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= LAST; i++) side[i] <= '0;
    end else begin
      side[0] <= side_in;
      for (int i = 1; i <= LAST; i++) side[i] <= side[i-1];
    end
  end

  // Datapath registers.
  logic [RAW_W-1:0] e_raw;
  logic [11:0]      e_diff;

  logic [31:0] nm      [0:1][0:NS];
  logic [4:0]  lz      [0:1][0:NS];
  logic [31:0] nm_next [0:1][0:NS];
  logic [4:0]  lz_next [0:1][0:NS];

  logic [31:0]   lm      [0:1][0:FB-1];
  logic [FB-1:0] lf      [0:1][0:FB-1];
  logic [4:0]    li      [0:1][0:FB-1];
  logic [31:0]   lm_next [0:1][0:FB-1];
  logic [FB-1:0] lf_next [0:1][0:FB-1];
  logic [4:0]    li_next [0:1][0:FB-1];

  logic signed [29:0] d;
  logic signed [45:0] prod;

  logic [31:0]       xm      [0:FB-1];
  logic [FB-1:0]     xf      [0:FB-1];
  logic signed [9:0] xi      [0:FB-1];
  logic [31:0]       xm_next [0:FB-1];
  logic [FB-1:0]     xf_next [0:FB-1];
  logic signed [9:0] xi_next [0:FB-1];

  logic [55:0]        p_hi;
  logic [55:0]        p_lo;
  logic signed [10:0] sh_a;
  logic [79:0]        pfull;
  logic signed [10:0] sh_b;
  logic [39:0]        q;
  logic               qsat;

  // Normalize: five shift steps of 16, 8, 4, 2, 1 bring the top bit to bit 31.
  always_comb begin
    logic [63:0] sq;
    logic [31:0] m_in;
    logic [FB-1:0] f_in;
    logic [4:0] i_in;
    nm_next[0][0] = 32'(series_resistance) * 32'(e_diff);
    nm_next[1][0] = 32'(e_raw);
    lz_next[0][0] = '0;
    lz_next[1][0] = '0;
    for (int ln = 0; ln < 2; ln++) begin
      for (int s = 0; s < NS; s++) begin
        if ((nm[ln][s] >> (32 - (16 >> s))) == '0) begin
          nm_next[ln][s+1] = nm[ln][s] << (16 >> s);
          lz_next[ln][s+1] = lz[ln][s] + 5'(16 >> s);
        end else begin
          nm_next[ln][s+1] = nm[ln][s];
          lz_next[ln][s+1] = lz[ln][s];
        end
      end
      // Fraction of log2: one squaring of the mantissa per stage.
      for (int k = 0; k < FB; k++) begin
        if (k == 0) begin
          m_in = nm[ln][NS];
          f_in = '0;
          i_in = 5'd31 - lz[ln][NS];
        end else begin
          m_in = lm[ln][k-1];
          f_in = lf[ln][k-1];
          i_in = li[ln][k-1];
        end
        sq = 64'(m_in) * 64'(m_in);
        lm_next[ln][k] = sq[63] ? sq[63:32] : sq[62:31];
        lf_next[ln][k] = f_in | (FB'(sq[63]) << (FB - 1 - k));
        li_next[ln][k] = i_in;
      end
    end
  end

  // Power: 2^f as a product of table factors, one factor per stage.
  always_comb begin
    logic [63:0] pr;
    logic [31:0] m_in;
    logic [FB-1:0] f_in;
    logic signed [9:0] i_in;
    for (int k = 0; k < FB; k++) begin
      if (k == 0) begin
        m_in = 32'h8000_0000;
        f_in = prod[FB+11:12];
        i_in = prod[45:FB+12];
      end else begin
        m_in = xm[k-1];
        f_in = xf[k-1];
        i_in = xi[k-1];
      end
      pr = 64'(m_in) * 64'(ldr_lux_pkg::EXP_TAB[(FB-1-k)*32 +: 32]);
      xm_next[k] = f_in[FB-1-k] ? pr[62:31] : m_in;
      xf_next[k] = f_in;
      xi_next[k] = i_in;
    end
  end

  // Final shift by 2^ip and saturation to 40 bits.
  logic [39:0] q_next;
  logic        qsat_next;
  always_comb begin
    logic [79:0] shr;
    logic [10:0] t;
    shr = '0;
    t   = 11'(-sh_b);
    if (!sh_b[10]) begin
      shr       = pfull >> sh_b;
      q_next    = shr[39:0];
      qsat_next = |shr[79:40];
    end else if (t >= 11'd40) begin
      q_next    = '0;
      qsat_next = |pfull;
    end else begin
      shr       = pfull >> (7'd40 - 7'(t));
      q_next    = 40'(pfull << t);
      qsat_next = |shr;
    end
  end

  always_ff @(posedge clk) begin
    e_raw  <= raw;
    e_diff <= 12'(fs_w - raw);
    nm <= nm_next;
    lz <= lz_next;
    lm <= lm_next;
    lf <= lf_next;
    li <= li_next;
    d <= $signed({1'b0, li[0][FB-1], lf[0][FB-1]})
       - $signed({1'b0, li[1][FB-1], lf[1][FB-1]});
    prod <= d * lux_exponent;
    xm <= xm_next;
    xf <= xf_next;
    xi <= xi_next;
    p_hi  <= 56'(lux_scalar[47:24]) * 56'(xm[FB-1]);
    p_lo  <= 56'(lux_scalar[23:0]) * 56'(xm[FB-1]);
    sh_a  <= 11'sd39 - $signed({xi[FB-1][9], xi[FB-1]});
    pfull <= (80'(p_hi) << 24) + 80'(p_lo);
    sh_b  <= sh_a;
    q     <= q_next;
    qsat  <= qsat_next;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= side[LAST].valid;
    end
    if (side[LAST].spec) begin
      value  <= side[LAST].sval;
      status <= side[LAST].sst;
    end else if (qsat) begin
      value  <= ldr_lux_pkg::VALUE_MAX;
      status <= ldr_lux_pkg::ST_SAT;
    end else begin
      value  <= {1'b0, q};
      status <= ldr_lux_pkg::ST_OK;
    end
  end

endmodule

// File: rtl/ldr_lux_chk.sv
// Port-level checker for the LDR lux converter, bound to the top level.
module ldr_lux_chk (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic signed [40:0] value,
  input logic [1:0]         status
);

  a_no_res_value: assert property (@(posedge clk) disable iff (rst)
    done && status == ldr_lux_pkg::ST_NO_RES |-> value == ldr_lux_pkg::VALUE_NEG_ONE)
    else $error("unset resistor result is not -1.0");

  a_range_value: assert property (@(posedge clk) disable iff (rst)
    done && status == ldr_lux_pkg::ST_RANGE |-> value == '0)
    else $error("out-of-range sample result is not zero");

  a_negative_only_unset: assert property (@(posedge clk) disable iff (rst)
    done && value[40] |-> status == ldr_lux_pkg::ST_NO_RES)
    else $error("negative result without unset-resistor status");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, ldr_lux_pkg::LATENCY))
    else $error("result transfer without a sample accepted at the fixed latency");

endmodule

bind ldr_adc_to_lux_top ldr_lux_chk u_ldr_lux_chk (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .value  (value),
  .status (status)
);

// File: bench/ldr_adc_to_lux_tb.sv
// Self-checking testbench for the LDR lux converter: directed and random samples.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [40:0]   value;
    ldr_lux_pkg::status_t status;
  } lux_result_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic [11:0] sample;
  logic        busy;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [47:0] cfg_data;
  logic        done;
  logic signed [40:0] value;
  logic [1:0]  status;

  ldr_adc_to_lux_top i_dut (
    .clk(clk), .rst(rst), .start(start), .sample(sample), .busy(busy),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .value(value), .status(status)
  );

  // Shadow copy of the configuration registers.
  logic [11:0]        fs_q;
  logic [19:0]        rs_q;
  logic [47:0]        scalar_q;
  logic signed [15:0] exp_q;
  logic               publish_q;

  logic [63:0] root_tab [24];
  lux_result_t pending_lux[$];
  int errors;
  int mismatches;
  int items_sent;
  int results_seen;
  int cfg_writes;
  int max_gap;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] t;
    res = '0;
    for (int b = 31; b >= 0; b--) begin
      t = res | (64'd1 << b);
      if (t * t <= v) res = t;
    end
    return res;
  endfunction

  function automatic int msb_of(logic [127:0] x);
    int n;
    n = -1;
    for (int i = 0; i < 128; i++) if (x[i]) n = i;
    return n;
  endfunction

  // Base-2 logarithm of a positive integer with 24 fraction bits.
  function automatic longint log2_fix(logic [63:0] x);
    int msb;
    logic [63:0] m;
    longint frac;
    msb  = msb_of({64'd0, x});
    m    = (msb <= 31) ? (x << (31 - msb)) : (x >> (msb - 31));
    frac = 0;
    for (int k = 23; k >= 0; k--) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        frac = frac | (longint'(1) << k);
        m = m >> 1;
      end
    end
    return (longint'(msb) << 24) | frac;
  endfunction

  function automatic lux_result_t lux_predict(logic [11:0] raw);
    lux_result_t r;
    logic [63:0]  num;
    longint       d;
    longint       yq;
    longint       ip;
    longint       sh;
    logic [63:0]  mant;
    logic [127:0] prod;
    r.status = ldr_lux_pkg::ST_OK;
    r.value  = '0;
    if (!publish_q) begin
      r.value = {21'd0, raw, 8'd0};
    end else if (rs_q == 0) begin
      r.value  = -41'sd256;
      r.status = ldr_lux_pkg::ST_NO_RES;
    end else if (raw > fs_q) begin
      r.status = ldr_lux_pkg::ST_RANGE;
    end else if (raw == 0) begin
      r.status = ldr_lux_pkg::ST_SAT;
      if (exp_q == 0) r.value = {1'b0, scalar_q[47:8]};
      else if (exp_q > 0) r.value = ldr_lux_pkg::VALUE_MAX;
    end else if (raw == fs_q) begin
      if (exp_q == 0) begin
        r.value = {1'b0, scalar_q[47:8]};
      end else if (exp_q < 0) begin
        r.value  = ldr_lux_pkg::VALUE_MAX;
        r.status = ldr_lux_pkg::ST_SAT;
      end
    end else begin
      num  = 64'(rs_q) * 64'(fs_q - raw);
      d    = log2_fix(num) - log2_fix(64'(raw));
      yq   = (d * longint'(exp_q)) >>> 12;
      ip   = yq >>> 24;
      mant = 64'h8000_0000;
      for (int k = 23; k >= 0; k--)
        if (yq[k]) mant = (mant * root_tab[k]) >> 31;
      prod = 128'(scalar_q) * 128'(mant);
      sh   = 39 - ip;
      if (sh < 0) begin
        if (prod != 0) begin
          if (msb_of(prod) + 1 - sh > 40) begin
            r.value  = ldr_lux_pkg::VALUE_MAX;
            r.status = ldr_lux_pkg::ST_SAT;
          end else begin
            r.value = 41'(prod << (-sh));
          end
        end
      end else if (sh < 128) begin
        prod = prod >> sh;
        if (prod > 128'(ldr_lux_pkg::VALUE_MAX)) begin
          r.value  = ldr_lux_pkg::VALUE_MAX;
          r.status = ldr_lux_pkg::ST_SAT;
        end else begin
          r.value = 41'(prod);
        end
      end
    end
    return r;
  endfunction

  // Checks every strobed result against the oldest prediction.
  always @(posedge clk) begin
    lux_result_t e;
    if (!rst && done) begin
      results_seen++;
      if (pending_lux.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result value=%0d status=%0d", value, status);
      end else begin
        e = pending_lux.pop_front();
        if (value !== e.value || status !== e.status) begin
          errors++;
          if (mismatches++ < 10)
            $display("mismatch: expected value=%0d status=%0d, got value=%0d status=%0d",
                     e.value, e.status, value, status);
        end
      end
    end
  end

  task automatic send_sample(logic [11:0] s);
    int gap;
    gap = int'($urandom_range(0, max_gap));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    sample <= s;
    do @(posedge clk); while (busy);
    pending_lux.push_back(lux_predict(s));
    items_sent++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_lux.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [47:0] data);
    repeat ($urandom_range(0, max_gap)) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    case (idx)
      ldr_lux_pkg::REG_FULL_SCALE: fs_q      = data[11:0];
      ldr_lux_pkg::REG_SERIES_RES: rs_q      = data[19:0];
      ldr_lux_pkg::REG_SCALAR:     scalar_q  = data;
      ldr_lux_pkg::REG_EXPONENT:   exp_q     = data[15:0];
      ldr_lux_pkg::REG_PUBLISH:    publish_q = data[0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [11:0] fs, logic [19:0] rs, logic [47:0] sc,
                            logic [15:0] ex, logic pub);
    wait_idle();
    write_reg(ldr_lux_pkg::REG_FULL_SCALE, 48'(fs));
    write_reg(ldr_lux_pkg::REG_SERIES_RES, 48'(rs));
    write_reg(ldr_lux_pkg::REG_SCALAR, sc);
    write_reg(ldr_lux_pkg::REG_EXPONENT, 48'(ex));
    write_reg(ldr_lux_pkg::REG_PUBLISH, 48'(pub));
  endtask

  task automatic test_defaults();
    send_sample(12'd0);
    send_sample(12'd1);
    send_sample(12'd512);
    send_sample(12'd1022);
    send_sample(12'd1023);
    send_sample(12'd1024);
    send_sample(12'hFFF);
  endtask

  task automatic test_raw_mode();
    set_config(12'd1023, 20'd10000, ldr_lux_pkg::SCALAR_RST, ldr_lux_pkg::EXPONENT_RST, 1'b0);
    send_sample(12'd0);
    send_sample(12'hFFF);
    send_sample(12'hAAA);
    send_sample(12'h555);
  endtask

  task automatic test_special_cases();
    // Resistor not configured.
    set_config(12'd2000, 20'd0, ldr_lux_pkg::SCALAR_RST, ldr_lux_pkg::EXPONENT_RST, 1'b1);
    send_sample(12'd100);
    send_sample(12'd0);
    // Zero, positive and negative exponents, at zero, full-scale and in-between samples.
    set_config(12'd2000, 20'd4700, 48'hFFFF_FFFF_FFFF, 16'd0, 1'b1);
    send_sample(12'd0);
    send_sample(12'd2000);
    send_sample(12'd700);
    set_config(12'd2000, 20'd4700, ldr_lux_pkg::SCALAR_RST, 16'h7FFF, 1'b1);
    send_sample(12'd0);
    send_sample(12'd2000);
    send_sample(12'd1);
    set_config(12'd4095, 20'hFFFFF, 48'hFFFF_FFFF_FFFF, 16'h8000, 1'b1);
    send_sample(12'd4095);
    send_sample(12'd1);
    send_sample(12'd4094);
    set_config(12'd1, 20'd1, 48'd0, 16'h1000, 1'b1);
    send_sample(12'd1);
    send_sample(12'd2);
    send_sample(12'd0);
  endtask

  task automatic test_unused_index();
    wait_idle();
    write_reg(3'd5, 48'd0);
    write_reg(3'd6, 48'hFFFF_FFFF_FFFF);
    write_reg(3'd7, 48'd1);
    send_sample(12'd3);
  endtask

  task automatic test_random(int phases, int per_phase);
    logic [11:0] fs;
    logic [19:0] rs;
    logic [47:0] sc;
    logic [15:0] ex;
    logic [11:0] s;
    for (int p = 0; p < phases; p++) begin
      case ($urandom_range(0, 3))
        0: fs = 12'd1;
        1: fs = 12'hFFF;
        default: fs = 12'($urandom_range(2, 4094));
      endcase
      case ($urandom_range(0, 9))
        0: rs = 20'd0;
        1: rs = 20'hFFFFF;
        default: rs = 20'($urandom_range(1, 1048575));
      endcase
      sc = ($urandom_range(0, 2) == 0) ? ldr_lux_pkg::SCALAR_RST : 48'({$urandom, $urandom});
      ex = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                       : 16'($signed($urandom_range(0, 16000)) - 8000);
      set_config(fs, rs, sc, ex, $urandom_range(0, 5) != 0);
      max_gap = ($urandom_range(0, 2) == 0) ? 0 : 18;
      for (int i = 0; i < per_phase; i++) begin
        case ($urandom_range(0, 9))
          0: s = 12'($urandom);
          1: s = ($urandom_range(0, 1) == 0) ? 12'd0 : fs;
          default: s = 12'($urandom_range(0, fs));
        endcase
        send_sample(s);
      end
      max_gap = 18;
    end
  endtask

  initial begin
    logic [63:0] c;
    rst = 1'b1;
    start = 1'b0;
    sample = '0;
    cfg_valid = 1'b0;
    cfg_index = ldr_lux_pkg::REG_FULL_SCALE;
    cfg_data = '0;
    errors = 0;
    mismatches = 0;
    items_sent = 0;
    results_seen = 0;
    cfg_writes = 0;
    max_gap = 18;
    fs_q = ldr_lux_pkg::FULL_SCALE_RST;
    rs_q = ldr_lux_pkg::SERIES_RES_RST;
    scalar_q = ldr_lux_pkg::SCALAR_RST;
    exp_q = ldr_lux_pkg::EXPONENT_RST;
    publish_q = ldr_lux_pkg::PUBLISH_RST;
    c = 64'h1_0000_0000;
    for (int k = 23; k >= 0; k--) begin
      c = int_sqrt(c << 31);
      root_tab[k] = c;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_raw_mode();
    test_special_cases();
    test_unused_index();
    test_random(16, 40);
    wait_idle();
    repeat (ldr_lux_pkg::LATENCY + 10) @(posedge clk);
    $display("Covered %0d samples, %0d results, %0d register writes", items_sent,
             results_seen, cfg_writes);
    $display("over raw, unset-resistor, range, saturation and random lux settings.");
    if (errors == 0 && pending_lux.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches, %0d results still expected", mismatches, pending_lux.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results still expected", pending_lux.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
